// ===== rtl/core/rab_pkg.sv =====
// rab_pkg: shared types, register indexes and geometry helpers for the
// apron box block. Self-contained; imported by rab_geom, rab_pipe and the top.
`timescale 1ns / 1ps

package rab_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE_FLAGS    = 2'd0;
  localparam logic [1:0] CFG_WINDOW_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_HEIGHT = 2'd2;

  // mode flag bit positions
  localparam int FLAG_AUTO_CENTER = 0;
  localparam int FLAG_CONTINUOUS  = 1;
  localparam int FLAG_AUTO_ROTATE = 2;

  localparam int CfgIdxW = 2;
  localparam int CfgW    = 12;
  localparam int FlagW   = 3;
  localparam int DimW    = 12;
  localparam int EdgeW   = 13;
  localparam int PosW    = 16;
  localparam int Pos3W   = 18;
  localparam int ThrW    = 14;

  // reset values of the window size
  localparam logic [DimW-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DimW-1:0] HEIGHT_RST = 12'd480;

  // reciprocal of five, exact for arguments below 2**14
  localparam logic [26:0] RECIP5 = 27'd6554;

  typedef struct packed {
    logic [EdgeW-1:0] l;
    logic [EdgeW-1:0] t;
    logic [EdgeW-1:0] r;
    logic [EdgeW-1:0] b;
  } box_t;

  // per-axis figures derived from one window dimension
  typedef struct packed {
    logic [EdgeW-1:0] outer_lo;
    logic [EdgeW-1:0] outer_hi;
    logic [ThrW-1:0]  thr1;
    logic [ThrW-1:0]  thr2;
    logic [ThrW-1:0]  thr3;
    logic             dim_zero;
    logic [DimW-1:0]  quarter;
    logic [DimW-1:0]  three_eighths;
    logic [DimW-1:0]  half;
    logic [DimW-1:0]  three_quarters;
  } axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    box_t  track;
  } geom_t;

  // origin and extent of the inner box along one axis
  typedef struct packed {
    logic [DimW-1:0] org;
    logic [DimW-1:0] ext;
  } span_t;

  // floor(x / 5) for x < 16384
  function automatic logic [DimW-1:0] div5(input logic [ThrW-1:0] x);
    logic [26:0] p;
    p = {13'd0, x} * RECIP5;
    return p[26:15];
  endfunction

  function automatic axis_t calc_axis(input logic [DimW-1:0] n);
    axis_t a;
    logic [ThrW-1:0] n1, n2, n3;
    logic [DimW-1:0] ext;
    logic [DimW-1:0] gap;
    n1  = {2'd0, n};
    n2  = {1'b0, n, 1'b0};
    n3  = n1 + n2;
    ext = div5({n, 2'b00});
    gap = n - ext;
    a.outer_lo       = {2'd0, gap[DimW-1:1]};
    a.outer_hi       = {2'd0, gap[DimW-1:1]} + {1'b0, ext} + 13'd1;
    a.thr1           = n1;
    a.thr2           = n2;
    a.thr3           = n3;
    a.dim_zero       = (n == '0);
    a.quarter        = {2'd0, n[DimW-1:2]};
    a.three_eighths  = {1'b0, n3[DimW+1:3]};
    a.half           = {1'b0, n[DimW-1:1]};
    a.three_quarters = n3[DimW+1:2];
    return a;
  endfunction

  // inner box along one axis, chosen by the third that the position falls in
  function automatic span_t inner_span(input axis_t a, input logic signed [Pos3W-1:0] p3);
    span_t s;
    logic ge1, ge2, ge3;
    ge1 = !a.dim_zero && (p3 >= $signed({4'd0, a.thr1}));
    ge2 = !a.dim_zero && (p3 >= $signed({4'd0, a.thr2}));
    ge3 = !a.dim_zero && (p3 >= $signed({4'd0, a.thr3}));
    if (ge1 && !ge2) begin
      s.org = a.three_eighths;
      s.ext = a.quarter;
    end else begin
      s.ext = a.half;
      if (ge3)      s.org = a.three_quarters;
      else if (ge2) s.org = a.half;
      else          s.org = '0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/rab_geom.sv =====
// rab_geom: configuration registers and the registered window geometry
// derived from them. Depends on rab_pkg.
`timescale 1ns / 1ps

module rab_geom (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rab_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rab_pkg::CfgW-1:0]    cfg_wdata,
  output logic [rab_pkg::FlagW-1:0]   mode_flags,
  output rab_pkg::geom_t              geom
);
  import rab_pkg::*;

  logic [FlagW-1:0] flags_r;
  logic [DimW-1:0]  width_r;
  logic [DimW-1:0]  height_r;
  geom_t            geom_r;
  geom_t            geom_nxt;
  logic [DimW-1:0]  tw;
  logic [DimW-1:0]  th;

  // register writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE_FLAGS:    flags_r  <= cfg_wdata[FlagW-1:0];
        CFG_WINDOW_WIDTH:  width_r  <= cfg_wdata;
        CFG_WINDOW_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // derived geometry: outer box, third thresholds, inner candidates, track box
  always_comb begin
    tw = div5({2'd0, width_r});
    th = div5({1'b0, height_r, 1'b0});
    geom_nxt.x       = calc_axis(width_r);
    geom_nxt.y       = calc_axis(height_r);
    geom_nxt.track.l = {tw, 1'b0};
    geom_nxt.track.r = {tw, 1'b0} + {1'b0, tw} + 13'd1;
    geom_nxt.track.t = {2'd0, height_r[DimW-1:1]};
    geom_nxt.track.b = {2'd0, height_r[DimW-1:1]} + {1'b0, th} + 13'd1;
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign mode_flags = flags_r;
  assign geom       = geom_r;

endmodule

// ===== rtl/core/rab_pipe.sv =====
// rab_pipe: five-stage datapath from ship position to apron box, with a
// valid bit and local ready at each stage. Depends on rab_pkg.
`timescale 1ns / 1ps

module rab_pipe (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [rab_pkg::FlagW-1:0] mode_flags,
  input  rab_pkg::geom_t            geom,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        in_ship_col,
  input  logic signed [15:0]        in_ship_row,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rab_pkg::box_t             out_box
);
  import rab_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  logic signed [PosW-1:0]  col1_r, row1_r;
  logic signed [PosW-1:0]  col2_r, row2_r;
  logic signed [Pos3W-1:0] col3x_r, row3x_r;
  logic                    inside3_r, inside3_nxt;
  span_t                   sx3_r, sy3_r;
  logic                    inside4_r;
  box_t                    meet4_r, meet4_nxt;
  box_t                    out_r, out_nxt;

  logic [EdgeW-1:0] il, ir, it, ib;
  logic             disjoint;

  // ready ripples back through empty or draining stages
  assign rdyo     = !vo_r || out_ready;
  assign rdy4     = !v4_r || rdyo;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  // stage 1: capture the position on transfer
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      col1_r <= in_ship_col;
      row1_r <= in_ship_row;
    end
  end

  // stage 2: three times the position for the thirds test
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      col2_r  <= col1_r;
      row2_r  <= row1_r;
      col3x_r <= (Pos3W'(col1_r) <<< 1) + Pos3W'(col1_r);
      row3x_r <= (Pos3W'(row1_r) <<< 1) + Pos3W'(row1_r);
    end
  end

  // stage 3: containment in the outer box and inner box selection
  always_comb begin
    inside3_nxt = (col2_r >= $signed({3'd0, geom.x.outer_lo})) &&
                  (col2_r <  $signed({3'd0, geom.x.outer_hi})) &&
                  (row2_r >= $signed({3'd0, geom.y.outer_lo})) &&
                  (row2_r <  $signed({3'd0, geom.y.outer_hi}));
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      inside3_r <= inside3_nxt;
      sx3_r     <= inner_span(geom.x, col3x_r);
      sy3_r     <= inner_span(geom.y, row3x_r);
    end
  end

  // stage 4: intersection of outer and inner boxes
  always_comb begin
    il = {1'b0, sx3_r.org};
    ir = {1'b0, sx3_r.org} + {1'b0, sx3_r.ext} + 13'd1;
    it = {1'b0, sy3_r.org};
    ib = {1'b0, sy3_r.org} + {1'b0, sy3_r.ext} + 13'd1;
    meet4_nxt.l = (geom.x.outer_lo > il) ? geom.x.outer_lo : il;
    meet4_nxt.r = (geom.x.outer_hi < ir) ? geom.x.outer_hi : ir;
    meet4_nxt.t = (geom.y.outer_lo > it) ? geom.y.outer_lo : it;
    meet4_nxt.b = (geom.y.outer_hi < ib) ? geom.y.outer_hi : ib;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      inside4_r <= inside3_r;
      meet4_r   <= meet4_nxt;
    end
  end

  // output stage: disjoint check and mode selection
  always_comb begin
    disjoint = (meet4_r.r <= meet4_r.l) || (meet4_r.b <= meet4_r.t);
    priority if (!mode_flags[FLAG_AUTO_CENTER] || mode_flags[FLAG_CONTINUOUS]) begin
      out_nxt = '0;
    end else if (mode_flags[FLAG_AUTO_ROTATE]) begin
      out_nxt = geom.track;
    end else if (!inside4_r) begin
      out_nxt.l = geom.x.outer_lo;
      out_nxt.r = geom.x.outer_hi;
      out_nxt.t = geom.y.outer_lo;
      out_nxt.b = geom.y.outer_hi;
    end else if (disjoint) begin
      out_nxt = '0;
    end else begin
      out_nxt = meet4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo && v4_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_box   = out_r;

endmodule

// ===== rtl/core/recenter_apron_box_top.sv =====
// recenter_apron_box_top: top level of the moving-map apron box block.
// Instantiates rab_geom and rab_pipe; depends on rab_pkg.
`timescale 1ns / 1ps

// Takes one ship position per transfer and returns one apron rectangle per
// position, in order. The datapath is a five-stage pipeline: a position is
// accepted every cycle unless a stalled output backs up to the input, and
// its rectangle passes through stages one to four and the output register
// before it is presented. A stalled output holds the full stages in place,
// while empty stages still take new data. Window geometry (fifths, quarters,
// eighths, halves and thresholds) is registered from the configuration
// registers and is first used in the pipeline's third stage, so a position
// may follow a configuration write in the next cycle. Write configuration
// only while no position is in flight.
module recenter_apron_box_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rab_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rab_pkg::CfgW-1:0]    cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_ship_col,
  input  logic signed [15:0]          in_ship_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [12:0]                 out_apron_left,
  output logic [12:0]                 out_apron_top,
  output logic [12:0]                 out_apron_right,
  output logic [12:0]                 out_apron_bottom
);
  import rab_pkg::*;

  logic [FlagW-1:0] mode_flags;
  geom_t            geom;
  box_t             box;

  // configuration and derived geometry
  rab_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mode_flags (mode_flags),
    .geom       (geom)
  );

  // position to rectangle pipeline
  rab_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .mode_flags  (mode_flags),
    .geom        (geom),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_ship_col (in_ship_col),
    .in_ship_row (in_ship_row),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_box     (box)
  );

  assign out_apron_left   = box.l;
  assign out_apron_top    = box.t;
  assign out_apron_right  = box.r;
  assign out_apron_bottom = box.b;

endmodule

// ===== sim/tb_recenter_apron_box_top.sv =====
// tb_recenter_apron_box_top: self-checking testbench for the apron box block.
// Depends on rab_pkg and recenter_apron_box_top; a directed table and then random
// phases, checked against a behavioral apron predictor.
`timescale 1ns / 1ps

module tb_recenter_apron_box_top;
  import rab_pkg::*;

  localparam int IDLE_PCT    = 12;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASES      = 16;
  localparam int PHASE_FIXES = 25;
  localparam int PLAN_LEN    = 25;

  // unused register index, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  // mode flag settings used by name
  localparam logic [FlagW-1:0] MODE_OFF       = 3'b000;
  localparam logic [FlagW-1:0] MODE_NORTH_UP  = 3'b001;
  localparam logic [FlagW-1:0] MODE_CONT_ONLY = 3'b010;
  localparam logic [FlagW-1:0] MODE_CONT      = 3'b011;
  localparam logic [FlagW-1:0] MODE_ROT_ONLY  = 3'b100;
  localparam logic [FlagW-1:0] MODE_TRACK_UP  = 3'b101;
  localparam logic [FlagW-1:0] MODE_ROT_CONT  = 3'b110;
  localparam logic [FlagW-1:0] MODE_ALL       = 3'b111;

  // aprons that follow directly from a 640 x 480 window
  localparam box_t NO_APRON  = '{l: 13'd0, t: 13'd0, r: 13'd0, b: 13'd0};
  localparam box_t TRACK_640 = '{l: 13'd256, t: 13'd240, r: 13'd385, b: 13'd433};
  localparam box_t OUTER_640 = '{l: 13'd64, t: 13'd48, r: 13'd577, b: 13'd433};

  typedef struct {
    logic [FlagW-1:0]   flags;
    logic [DimW-1:0]    w;
    logic [DimW-1:0]    h;
    logic signed [15:0] col;
    logic signed [15:0] row;
    bit                 typed;
    box_t               want;
  } fix_row_t;

  typedef struct {
    int l;
    int t;
    int r;
    int b;
  } rect_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgW-1:0]      cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [15:0]   in_ship_col;
  logic signed [15:0]   in_ship_row;
  logic                 out_valid;
  logic                 out_ready;
  logic [12:0]          out_apron_left;
  logic [12:0]          out_apron_top;
  logic [12:0]          out_apron_right;
  logic [12:0]          out_apron_bottom;

  // predictor copy of the registers
  logic [FlagW-1:0] mode_now;
  logic [DimW-1:0]  width_now;
  logic [DimW-1:0]  height_now;

  box_t apron_due[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   steady_run = 1'b0;
  int   hold_asks = 0;
  int   hold_seen = 0;

  // directed positions: modes, window extremes, edges and thirds of the outer box
  fix_row_t plan [PLAN_LEN] = '{
    '{MODE_OFF,       12'd640,  12'd480,  16'sd0,     16'sd0,     1'b1, NO_APRON},
    '{MODE_OFF,       12'd640,  12'd480,  16'sh8000,  16'sh7FFF,  1'b1, NO_APRON},
    '{MODE_CONT,      12'd640,  12'd480,  16'sd320,   16'sd240,   1'b1, NO_APRON},
    '{MODE_ALL,       12'd640,  12'd480,  16'sd100,   16'sd100,   1'b1, NO_APRON},
    '{MODE_CONT_ONLY, 12'd640,  12'd480,  16'sd5,     16'sd5,     1'b1, NO_APRON},
    '{MODE_TRACK_UP,  12'd640,  12'd480,  16'sd320,   16'sd240,   1'b1, TRACK_640},
    '{MODE_TRACK_UP,  12'd640,  12'd480,  16'sh8000,  16'sh8000,  1'b1, TRACK_640},
    '{MODE_ROT_CONT,  12'd640,  12'd480,  16'sd320,   16'sd240,   1'b1, NO_APRON},
    '{MODE_ROT_ONLY,  12'd640,  12'd480,  16'sd320,   16'sd240,   1'b1, NO_APRON},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sh8000,  16'sh8000,  1'b1, OUTER_640},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sh7FFF,  16'sh7FFF,  1'b1, OUTER_640},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sd577,   16'sd240,   1'b1, OUTER_640},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  -16'sd1,    16'sd240,   1'b1, OUTER_640},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sd320,   16'sd240,   1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sd64,    16'sd48,    1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sd576,   16'sd432,   1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sd213,   16'sd159,   1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sd214,   16'sd160,   1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd640,  12'd480,  16'sd427,   16'sd320,   1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd4095, 12'd4095, 16'sd2000,  16'sd3000,  1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd1,    12'd1,    16'sd0,     16'sd0,     1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd0,    12'd0,    16'sd0,     16'sd0,     1'b0, NO_APRON},
    '{MODE_NORTH_UP,  12'd0,    12'd480,  16'sd0,     16'sd240,   1'b0, NO_APRON},
    '{MODE_TRACK_UP,  12'd0,    12'd0,    16'sd0,     16'sd0,     1'b0, NO_APRON},
    '{MODE_TRACK_UP,  12'd4095, 12'd4095, 16'sd100,   16'sd100,   1'b0, NO_APRON}
  };

  recenter_apron_box_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ship_col      (in_ship_col),
    .in_ship_row      (in_ship_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_apron_left   (out_apron_left),
    .out_apron_top    (out_apron_top),
    .out_apron_right  (out_apron_right),
    .out_apron_bottom (out_apron_bottom)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // box spanning x .. x+w inclusive, right and bottom kept exclusive
  function automatic rect_t span_rect(input int x, input int y, input int w, input int h);
    rect_t s;
    s.l = x;
    s.t = y;
    s.r = x + w + 1;
    s.b = y + h + 1;
    return s;
  endfunction

  // which third of the window a position falls in, zero size gives zero
  function automatic int third_of(input int pos, input int size);
    return (size <= 0) ? 0 : (3 * pos) / size;
  endfunction

  function automatic box_t predict_apron(input logic signed [15:0] col,
                                         input logic signed [15:0] row);
    int    w, h, c, rw, bw, bh, ix, iy, x0, y0;
    rect_t hit, inner;
    box_t  want;
    w  = width_now;
    h  = height_now;
    c  = col;
    rw = row;
    hit = '{0, 0, 0, 0};
    if (mode_now[FLAG_AUTO_CENTER] && !mode_now[FLAG_CONTINUOUS]) begin
      if (mode_now[FLAG_AUTO_ROTATE]) begin
        // track-up: fixed box from fifths and halves
        hit = span_rect(2 * (w / 5), h / 2, w / 5, (2 * h) / 5);
      end else begin
        // north-up: outer box of four fifths
        bw  = (4 * w) / 5;
        bh  = (4 * h) / 5;
        hit = span_rect((w - bw) / 2, (h - bh) / 2, bw, bh);
        if (c >= hit.l && c < hit.r && rw >= hit.t && rw < hit.b) begin
          ix = third_of(c, w);
          iy = third_of(rw, h);
          if (ix == 1) begin
            bw = w / 4;
            x0 = (3 * w) / 8;
          end else begin
            bw = w / 2;
            x0 = (ix * w) / 4;
          end
          if (iy == 1) begin
            bh = h / 4;
            y0 = (3 * h) / 8;
          end else begin
            bh = h / 2;
            y0 = (iy * h) / 4;
          end
          // intersect with the inner box, empty overlap collapses to zero
          inner = span_rect(x0, y0, bw, bh);
          if (inner.l > hit.l) hit.l = inner.l;
          if (inner.t > hit.t) hit.t = inner.t;
          if (inner.r < hit.r) hit.r = inner.r;
          if (inner.b < hit.b) hit.b = inner.b;
          if (hit.r <= hit.l || hit.b <= hit.t) hit = '{0, 0, 0, 0};
        end
      end
    end
    want.l = EdgeW'(hit.l);
    want.t = EdgeW'(hit.t);
    want.r = EdgeW'(hit.r);
    want.b = EdgeW'(hit.b);
    return want;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // offer one position, record its apron once the transfer happens
  task automatic send_fix(input logic signed [15:0] col, input logic signed [15:0] row,
                          input bit typed, input box_t want);
    if (!steady_run)
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid    <= 1'b1;
    in_ship_col <= col;
    in_ship_row <= row;
    do @(posedge clk); while (!in_ready);
    apron_due.push_back(typed ? want : predict_apron(col, row));
  endtask

  // stop offering and let every pending apron come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (apron_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(input logic [FlagW-1:0] flags, input logic [DimW-1:0] w,
                           input logic [DimW-1:0] h);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE_FLAGS;
    cfg_wdata <= {(CfgW - FlagW)'($urandom), flags};
    @(posedge clk);
    cfg_index <= CFG_WINDOW_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    // spare index last, so a stray write would stick
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CfgW'($urandom);
    @(posedge clk);
    cfg_we     <= 1'b0;
    mode_now   = flags;
    width_now  = w;
    height_now = h;
  endtask

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DimW'($urandom_range(1, 7));
      2:       return {DimW{1'b1}};
      3, 4:    return DimW'($urandom_range(8, 64));
      default: return DimW'($urandom);
    endcase
  endfunction

  // mostly inside the window, some near zero below, some anywhere
  function automatic logic signed [15:0] pick_pos(input int span);
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(0, 3)) - 16'd4;
      default: return 16'($urandom_range(0, span + 1));
    endcase
  endfunction

  // apron sink: random ready, long hold-off on request, field checks
  initial begin : apron_sink
    int   hold_left;
    box_t want;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (apron_due.size() == 0) begin
          flag_mismatch("apron with no position pending");
        end else begin
          want = apron_due.pop_front();
          if (out_apron_left !== want.l)
            flag_mismatch($sformatf("left %0d, want %0d", out_apron_left, want.l));
          if (out_apron_top !== want.t)
            flag_mismatch($sformatf("top %0d, want %0d", out_apron_top, want.t));
          if (out_apron_right !== want.r)
            flag_mismatch($sformatf("right %0d, want %0d", out_apron_right, want.r));
          if (out_apron_bottom !== want.b)
            flag_mismatch($sformatf("bottom %0d, want %0d", out_apron_bottom, want.b));
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin : fix_source
    logic [FlagW-1:0] flags;
    logic [DimW-1:0]  w, h;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_MODE_FLAGS;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_ship_col <= '0;
    in_ship_row <= '0;
    mode_now   = MODE_OFF;
    width_now  = WIDTH_RST;
    height_now = HEIGHT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].flags != mode_now || plan[i].w != width_now || plan[i].h != height_now)
        load_regs(plan[i].flags, plan[i].w, plan[i].h);
      send_fix(plan[i].col, plan[i].row, plan[i].typed, plan[i].want);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      flags = ($urandom_range(0, 9) < 6) ? MODE_NORTH_UP : FlagW'($urandom);
      w = pick_dim();
      h = pick_dim();
      if (ph == 0) begin
        flags = MODE_NORTH_UP;
        w     = {DimW{1'b1}};
        h     = {DimW{1'b1}};
      end else if (ph == 1) begin
        w = DimW'(1);
        h = DimW'(1);
      end else if (ph == 2) begin
        flags = MODE_NORTH_UP;
        w     = '0;
        h     = DimW'($urandom_range(1, 40));
      end
      load_regs(flags, w, h);
      steady_run = (ph == 4);
      // stall the sink long enough for the input side to back up
      if (ph == 6) hold_asks++;
      for (int n = 0; n < PHASE_FIXES; n++)
        send_fix(pick_pos(int'(w)), pick_pos(int'(h)), 1'b0, NO_APRON);
    end

    steady_run = 1'b0;
    wait_idle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rab_pkg.sv
rtl/core/rab_geom.sv
rtl/core/rab_pipe.sv
rtl/core/recenter_apron_box_top.sv
sim/tb_recenter_apron_box_top.sv
